### rtl/token_repetition_penalty_assert.svh
// Assertion macros for the token repetition penalty block.
// No dependencies; the including module must provide i_clk and i_rst_n.
`ifndef TOKEN_REPETITION_PENALTY_ASSERT_SVH
`define TOKEN_REPETITION_PENALTY_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, off during reset.
`define TRP_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, off during reset.
`define TRP_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TRP_ASSERT_IMP(name, ante, cons, msg)
`define TRP_ASSERT_NXT(name, ante, cons, msg)
`endif
`endif

### rtl/trp_pkg.sv
// Shared constants and codes for the token repetition penalty block.
// No dependencies.
package trp_pkg;

    localparam int ID_W     = 15;
    localparam int LOGIT_W  = 24;
    localparam int OCC_W    = 7;
    localparam int CFG_W    = 16;
    localparam int CFG_AW   = 3;
    localparam int WLEN_W   = 7;

    // shared multiplier operands and working width
    localparam int MA_W     = 25;
    localparam int MB_W     = 17;
    localparam int RW       = 42;

    // restoring divider: numerator width and step counter width
    localparam int DIV_W    = 36;
    localparam int DIV_CW   = 6;

    localparam int LOGIT_MAX = 8388607;
    localparam int LOGIT_MIN = -8388608;
    localparam int OCC_MAX   = 127;
    localparam int Q12_ONE   = 4096;
    localparam int Q12_HALF  = 2048;
    localparam int Q12_SHIFT = 12;
    localparam int PEN_SHIFT = 4;

    // operation codes
    localparam logic OP_OBSERVE  = 1'b0;
    localparam logic OP_PENALIZE = 1'b1;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_WINDOW_LEN = 3'd0;
    localparam logic [CFG_AW-1:0] REG_REPEAT     = 3'd1;
    localparam logic [CFG_AW-1:0] REG_FREQ       = 3'd2;
    localparam logic [CFG_AW-1:0] REG_PRES       = 3'd3;
    localparam logic [CFG_AW-1:0] REG_PEN_NL     = 3'd4;
    localparam logic [CFG_AW-1:0] REG_NEWLINE    = 3'd5;

    // register reset values
    localparam logic [WLEN_W-1:0] RST_WINDOW_LEN = 7'd64;
    localparam logic [15:0]       RST_REPEAT     = 16'd4096;
    localparam logic [ID_W-1:0]   RST_NEWLINE    = 15'd13;

endpackage

### rtl/trp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module trp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read returns old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/token_repetition_penalty.sv
// Token repetition penalty: top level with sequencer and shared arithmetic.
// Depends on trp_pkg, trp_ram and token_repetition_penalty_assert.svh.
//
// Usage
//   Command channel: an item transfers at a rising edge with start high and
//   busy low. i_op selects observe (push i_token_id into the history window,
//   no result) or penalize (score i_token_id / i_logit_in, one result).
//   Result channel: o_valid is high for exactly one cycle with o_cand_id,
//   o_logit_out, o_occurrences and o_clipped; the receiver cannot stall it,
//   so it must take the transfer in that cycle.
//   Config port: i_cfg_we / i_cfg_addr / i_cfg_data, written at the edge,
//   no wait; write only while busy is low and no result is pending.
// Sequencing (one item at a time, busy high meanwhile)
//   observe: no work with window zero; before the window fills, a new count
//   read-modify-write only; once it is full, ring read, evicted count
//   read-modify-write, then new count read-modify-write through the single
//   count RAM port pair. penalize: straight to the result when no penalty
//   applies, multiply only for a repeat factor of 1.0 or a non-positive logit,
//   the 36-step restoring divider for a positive logit, factor not 1.0 or 0.
// Reset and clearing
//   After reset, and after every write of window_len, the count store is
//   cleared one entry a cycle, all VOCAB entries (32768 by default), busy high.
//   The ring store is never cleared; only written entries are ever read.
`include "token_repetition_penalty_assert.svh"

module token_repetition_penalty #(
    parameter int WINDOW = 64,
    parameter int VOCAB  = 32768
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_op,
    input  logic [trp_pkg::ID_W-1:0]            i_token_id,
    input  logic signed [trp_pkg::LOGIT_W-1:0]  i_logit_in,
    output logic                                o_valid,
    output logic [trp_pkg::ID_W-1:0]            o_cand_id,
    output logic signed [trp_pkg::LOGIT_W-1:0]  o_logit_out,
    output logic [trp_pkg::OCC_W-1:0]           o_occurrences,
    output logic                                o_clipped,
    input  logic                                i_cfg_we,
    input  logic [trp_pkg::CFG_AW-1:0]          i_cfg_addr,
    input  logic [trp_pkg::CFG_W-1:0]           i_cfg_data
);

    import trp_pkg::*;

    localparam int CW  = $clog2(WINDOW + 1);               // count / fill width
    localparam int RAW = (WINDOW > 1) ? $clog2(WINDOW) : 1; // ring address
    localparam int VAW = $clog2(VOCAB);                     // count address
    localparam int WW  = (CW > WLEN_W) ? CW : WLEN_W;
    localparam int CWX = (CW > OCC_W) ? CW : OCC_W;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR,
        S_OBS_RING, S_OBS_OLD_RD, S_OBS_OLD_WR, S_OBS_INC_RD, S_OBS_INC_WR,
        S_PEN_RD, S_PEN_CHK, S_PEN_ROUND, S_PEN_DIV, S_PEN_PMUL, S_PEN_PSUB,
        S_PEN_DONE
    } t_state;

    // id modulo VOCAB by conditional subtraction; handles quotients below 256
    function automatic logic [VAW-1:0] f_vocab_idx(input logic [ID_W-1:0] id);
        logic [31:0] v;
        v = 32'(id);
        for (int k = 7; k >= 0; k--) begin
            if (v >= (32'(VOCAB) << k)) begin
                v = v - (32'(VOCAB) << k);
            end
        end
        return VAW'(v);
    endfunction

    // configuration
    logic [WLEN_W-1:0]       r_window_len;
    logic [15:0]             r_repeat;
    logic signed [15:0]      r_freq;
    logic signed [15:0]      r_pres;
    logic                    r_pen_nl;
    logic [ID_W-1:0]         r_newline;

    // sequencer and item state
    t_state                  r_state;
    logic                    r_op;
    logic [ID_W-1:0]         r_id;
    logic [VAW-1:0]          r_idx;
    logic signed [LOGIT_W-1:0] r_logit;
    logic [VAW-1:0]          r_old;
    logic [CW-1:0]           r_count;
    logic [RAW-1:0]          r_head;
    logic [CW-1:0]           r_filled;
    logic [VAW-1:0]          r_clr;
    logic                    r_sat_high;
    logic signed [RW-1:0]    r_res;
    logic signed [RW-1:0]    r_prod;
    logic [DIV_W-1:0]        r_num;
    logic [15:0]             r_rem;
    logic [DIV_CW-1:0]       r_iter;

    // combinational
    logic                    accept;
    logic                    wlen_wr;
    logic [CW-1:0]           win_eff;
    logic [CW:0]             pos_sum;
    logic [RAW-1:0]          ring_pos;
    logic [RAW-1:0]          head_next;
    logic [VAW-1:0]          in_idx;
    logic                    exempt;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic [16:0]             div_trial;
    logic                    div_qbit;
    logic [15:0]             div_rem_next;
    logic [DIV_W-1:0]        div_num_next;
    logic signed [RW-1:0]    rnd_sum;
    logic signed [RW-1:0]    pen_sum;
    logic [CWX-1:0]          cnt_x;

    // RAM ports
    logic                    cnt_we;
    logic [VAW-1:0]          cnt_waddr;
    logic [CW-1:0]           cnt_wdata;
    logic [VAW-1:0]          cnt_raddr;
    logic [CW-1:0]           cnt_rdata;
    logic                    ring_we;
    logic [VAW-1:0]          ring_rdata;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign wlen_wr = i_cfg_we && (i_cfg_addr == REG_WINDOW_LEN);
    assign in_idx  = f_vocab_idx(i_token_id);

    // effective window: window_len capped at WINDOW
    always_comb begin
        if (WW'(r_window_len) > WW'(WINDOW)) begin
            win_eff = CW'(WINDOW);
        end else begin
            win_eff = CW'(r_window_len);
        end
    end

    // oldest entry of the window: (head - window) modulo WINDOW
    always_comb begin
        pos_sum = (CW + 1)'(r_head) + (CW + 1)'(WINDOW) - (CW + 1)'(win_eff);
        if (pos_sum >= (CW + 1)'(WINDOW)) begin
            ring_pos = RAW'(pos_sum - (CW + 1)'(WINDOW));
        end else begin
            ring_pos = RAW'(pos_sum);
        end
        head_next = (r_head == RAW'(WINDOW - 1)) ? '0 : r_head + RAW'(1);
    end

    assign exempt = !r_pen_nl && (r_id == r_newline);

    // shared multiplier: logit magnitude x repeat factor, or count x weight
    always_comb begin
        if (r_state == S_PEN_PMUL) begin
            mul_a = $signed(MA_W'(r_count));
            mul_b = $signed({r_freq[15], r_freq});
        end else begin
            mul_a = -$signed({r_logit[LOGIT_W-1], r_logit});
            mul_b = $signed({1'b0, r_repeat});
        end
    end

    // one restoring divide step
    always_comb begin
        div_trial = {r_rem, r_num[DIV_W-1]};
        div_qbit  = (div_trial >= {1'b0, r_repeat});
        div_rem_next = div_qbit ? 16'(div_trial - {1'b0, r_repeat}) : div_trial[15:0];
        div_num_next = {r_num[DIV_W-2:0], div_qbit};
    end

    assign rnd_sum = r_prod + RW'(Q12_HALF);
    assign pen_sum = r_prod + RW'(r_pres);
    assign cnt_x   = CWX'(r_count);

    // count store port selection
    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = r_idx;
        cnt_wdata = '0;
        cnt_raddr = r_idx;
        unique case (r_state)
            S_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_clr;
            end
            S_OBS_OLD_RD: begin
                cnt_raddr = ring_rdata;
            end
            S_OBS_OLD_WR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_old;
                cnt_wdata = (cnt_rdata == '0) ? '0 : cnt_rdata - CW'(1);
            end
            S_OBS_INC_WR: begin
                cnt_we    = 1'b1;
                cnt_wdata = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + CW'(1);
            end
            default: begin
            end
        endcase
    end

    assign ring_we = (r_state == S_OBS_INC_WR);

    trp_ram #(.WIDTH(CW), .DEPTH(VOCAB)) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    trp_ram #(.WIDTH(VAW), .DEPTH(WINDOW)) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_head),
        .i_wdata (r_idx),
        .i_raddr (ring_pos),
        .o_rdata (ring_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= RST_WINDOW_LEN;
            r_repeat     <= RST_REPEAT;
            r_freq       <= '0;
            r_pres       <= '0;
            r_pen_nl     <= 1'b1;
            r_newline    <= RST_NEWLINE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_WINDOW_LEN: r_window_len <= i_cfg_data[WLEN_W-1:0];
                REG_REPEAT:     r_repeat     <= i_cfg_data;
                REG_FREQ:       r_freq       <= $signed(i_cfg_data);
                REG_PRES:       r_pres       <= $signed(i_cfg_data);
                REG_PEN_NL:     r_pen_nl     <= i_cfg_data[0];
                REG_NEWLINE:    r_newline    <= i_cfg_data[ID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // sequencer, history pointers and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_head     <= '0;
            r_filled   <= '0;
            r_op       <= OP_OBSERVE;
            r_sat_high <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (wlen_wr) begin
                // new window size empties the history
                r_state  <= S_CLEAR;
                r_clr    <= '0;
                r_head   <= '0;
                r_filled <= '0;
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (accept) begin
                            r_op       <= i_op;
                            r_id       <= i_token_id;
                            r_idx      <= in_idx;
                            r_logit    <= i_logit_in;
                            r_sat_high <= 1'b0;
                            if (i_op == OP_PENALIZE) begin
                                r_state <= S_PEN_RD;
                            end else if (win_eff == '0) begin
                                r_state <= S_IDLE;
                            end else if (r_filled >= win_eff) begin
                                r_state <= S_OBS_RING;
                            end else begin
                                r_state <= S_OBS_INC_RD;
                            end
                        end
                    end
                    S_CLEAR: begin
                        r_clr <= r_clr + VAW'(1);
                        if (r_clr == VAW'(VOCAB - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_OBS_RING: begin
                        r_state <= S_OBS_OLD_RD;
                    end
                    S_OBS_OLD_RD: begin
                        r_old   <= ring_rdata;
                        r_state <= S_OBS_OLD_WR;
                    end
                    S_OBS_OLD_WR: begin
                        r_state <= S_OBS_INC_RD;
                    end
                    S_OBS_INC_RD: begin
                        r_state <= S_OBS_INC_WR;
                    end
                    S_OBS_INC_WR: begin
                        r_head <= head_next;
                        if (r_filled < win_eff) begin
                            r_filled <= r_filled + CW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                    S_PEN_RD: begin
                        r_state <= S_PEN_CHK;
                    end
                    S_PEN_CHK: begin
                        r_count <= cnt_rdata;
                        r_res   <= RW'(r_logit);
                        if (exempt || (cnt_rdata == '0)) begin
                            r_state <= S_PEN_DONE;
                        end else if (r_repeat == 16'(Q12_ONE)) begin
                            r_state <= S_PEN_PMUL;
                        end else if (r_logit <= 0) begin
                            // product of magnitude and factor lands in r_prod now
                            r_state <= S_PEN_ROUND;
                        end else if (r_repeat == '0) begin
                            r_sat_high <= 1'b1;
                            r_state    <= S_PEN_DONE;
                        end else begin
                            // logit * 4096 + factor / 2, divided by factor
                            r_num   <= (DIV_W'(r_logit[LOGIT_W-2:0]) << Q12_SHIFT)
                                       + DIV_W'(r_repeat[15:1]);
                            r_rem   <= '0;
                            r_iter  <= '0;
                            r_state <= S_PEN_DIV;
                        end
                    end
                    S_PEN_ROUND: begin
                        // round half away from zero, then restore the sign
                        r_res   <= -(rnd_sum >>> Q12_SHIFT);
                        r_state <= S_PEN_PMUL;
                    end
                    S_PEN_DIV: begin
                        r_num  <= div_num_next;
                        r_rem  <= div_rem_next;
                        r_iter <= r_iter + DIV_CW'(1);
                        if (r_iter == DIV_CW'(DIV_W - 1)) begin
                            r_res   <= $signed(RW'(div_num_next));
                            r_state <= S_PEN_PMUL;
                        end
                    end
                    S_PEN_PMUL: begin
                        r_state <= S_PEN_PSUB;
                    end
                    S_PEN_PSUB: begin
                        // Q4.12 weights to Q8.16 logit
                        r_res   <= r_res - (pen_sum <<< PEN_SHIFT);
                        r_state <= S_PEN_DONE;
                    end
                    S_PEN_DONE: begin
                        o_valid       <= 1'b1;
                        o_cand_id     <= r_id;
                        o_occurrences <= (cnt_x > CWX'(OCC_MAX)) ? OCC_W'(OCC_MAX)
                                                                 : cnt_x[OCC_W-1:0];
                        if (r_sat_high || (r_res > RW'(LOGIT_MAX))) begin
                            o_logit_out <= LOGIT_W'(LOGIT_MAX);
                            o_clipped   <= 1'b1;
                        end else if (r_res < RW'(LOGIT_MIN)) begin
                            o_logit_out <= LOGIT_W'(LOGIT_MIN);
                            o_clipped   <= 1'b1;
                        end else begin
                            o_logit_out <= r_res[LOGIT_W-1:0];
                            o_clipped   <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    // checks
    `TRP_ASSERT_IMP(a_result_from_penalize, o_valid, r_op == OP_PENALIZE, "result without penalize")
    `TRP_ASSERT_NXT(a_result_single_cycle, o_valid, !o_valid, "result strobe longer than one cycle")
    `TRP_ASSERT_NXT(a_penalize_goes_busy, accept && (i_op == OP_PENALIZE), busy, "penalize not busy")
    `TRP_ASSERT_IMP(a_fill_in_range, 1'b1, r_filled <= CW'(WINDOW), "fill count beyond window")

endmodule
